/* design/bmhq_pkg.sv */
// Shared types and constants of the binary min-heap queue.
// Used by the controller, the datapath and the top level; no dependencies.
package bmhq_pkg;

   localparam int DEF_CAPACITY   = 64;
   localparam int DEF_DATA_WIDTH = 32;
   localparam int TOP_WIDTH      = 32;
   localparam int COUNT_WIDTH    = 7;

   typedef enum logic [1:0] {
      ST_DONE       = 2'd0,
      ST_POP_EMPTY  = 2'd1,
      ST_PUSH_FULL  = 2'd2
   } status_code_type;

   // Request kinds as carried on req_type
   localparam logic REQ_PUSH = 1'b0;
   localparam logic REQ_POP  = 1'b1;

   typedef enum logic [1:0] {
      RD_PARENT = 2'd0,
      RD_LAST   = 2'd1,
      RD_LEFT   = 2'd2,
      RD_RIGHT  = 2'd3
   } rd_sel_type;

   typedef struct packed {
      logic       latch_req;
      logic       push_init;
      logic       pop_init;
      logic       rd_en;
      rd_sel_type rd_sel;
      logic       latch_val;
      logic       latch_left;
      logic       place;
      logic       move_up;
      logic       move_down;
      logic       set_empty;
      logic       set_full;
   } ctrl_cmd_type;

   typedef struct packed {
      logic pop;
      logic full;
      logic empty;
      logic at_root;
      logic has_left;
      logic up_smaller;
      logic down_smaller;
   } dp_stat_type;

endpackage

/* design/binary_min_heap_queue.sv */
// Binary min-heap priority queue: top level joining controller and datapath.
// Depends on bmhq_pkg, bmhq_ctrl and bmhq_datapath.
//
// Usage: drive req_type (0 push, 1 pop) and req_push_value with start high;
// the item is taken at a rising edge where start is high and busy is low.
// busy stays high until the result is shown. Each item yields one result,
// held on the rsp_ ports for the single cycle rsp_valid is high: the minimum
// after the operation (zero when empty), its valid flag, the entry count and
// a status (done, pop on empty ignored, push on full dropped).
// A push sifts up and a pop sifts down, moving L levels (L <= log2 CAPACITY);
// a rejected push or pop goes from decode straight to the result.
// Each level costs one read of the single memory read port plus a compare,
// two reads for sift-down (left and right child). busy falls the cycle after
// rsp_valid, and only then can the next item be taken.
// Reset clears the count and the controller; memory contents need no clear.
// The receiver cannot stall: the rsp_ values may change once the next item is taken.
module binary_min_heap_queue #(
   parameter int CAPACITY   = bmhq_pkg::DEF_CAPACITY,
   parameter int DATA_WIDTH = bmhq_pkg::DEF_DATA_WIDTH
) (
   input  logic                                  clock,
   input  logic                                  reset,
   input  logic                                  start,
   output logic                                  busy,
   input  logic                                  req_type,
   input  logic signed [31:0]                    req_push_value,
   output logic                                  rsp_valid,
   output logic signed [bmhq_pkg::TOP_WIDTH-1:0] rsp_top_value,
   output logic                                  rsp_top_valid,
   output logic [bmhq_pkg::COUNT_WIDTH-1:0]      rsp_entry_count,
   output logic [1:0]                            rsp_status
);
   import bmhq_pkg::*;

   ctrl_cmd_type ctrl_cmd;
   dp_stat_type  dp_stat;

   bmhq_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .start     (start),
      .stat      (dp_stat),
      .cmd       (ctrl_cmd),
      .busy      (busy),
      .rsp_valid (rsp_valid)
   );

   bmhq_datapath #(
      .CAPACITY   (CAPACITY),
      .DATA_WIDTH (DATA_WIDTH)
   ) u_datapath (
      .clock          (clock),
      .reset          (reset),
      .cmd            (ctrl_cmd),
      .stat           (dp_stat),
      .req_type       (req_type),
      .req_push_value (req_push_value),
      .top_value      (rsp_top_value),
      .top_valid      (rsp_top_valid),
      .entry_count    (rsp_entry_count),
      .status         (rsp_status)
   );

   a_accept_busy: assert property (@(posedge clock) disable iff (reset)
      (start && !busy) |=> busy)
      else $error("accepted item did not raise busy");

   a_single_strobe: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |=> (!rsp_valid && !busy))
      else $error("result strobe longer than one cycle");

   a_one_write_source: assert property (@(posedge clock) disable iff (reset)
      $onehot0({ctrl_cmd.place, ctrl_cmd.move_up, ctrl_cmd.move_down}))
      else $error("conflicting heap write commands");

   a_empty_pop_result: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && (rsp_status == ST_POP_EMPTY)) |->
         (!rsp_top_valid && (rsp_entry_count == '0) && (rsp_top_value == '0)))
      else $error("ignored pop reported a non-empty heap");

endmodule

/* design/bmhq_ctrl.sv */
// Controller of the binary min-heap queue: sequences sift-up and sift-down.
// Depends on bmhq_pkg; drives the datapath by command struct only.
module bmhq_ctrl (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   start,
   input  bmhq_pkg::dp_stat_type  stat,
   output bmhq_pkg::ctrl_cmd_type cmd,
   output logic                   busy,
   output logic                   rsp_valid
);
   import bmhq_pkg::*;

   typedef enum logic [8:0] {
      S_IDLE     = 9'b000000001,
      S_DECODE   = 9'b000000010,
      S_UP_CHK   = 9'b000000100,
      S_UP_CMP   = 9'b000001000,
      S_POP_WAIT = 9'b000010000,
      S_DN_CHK   = 9'b000100000,
      S_DN_LEFT  = 9'b001000000,
      S_DN_CMP   = 9'b010000000,
      S_DONE     = 9'b100000000
   } state_type;

   state_type state_ff, state_in;

   always_comb begin
      state_in = state_ff;
      cmd      = '0;
      cmd.rd_sel = RD_PARENT;
      unique case (state_ff)
         S_IDLE: begin
            if (start) begin
               cmd.latch_req = 1'b1;
               state_in      = S_DECODE;
            end
         end
         S_DECODE: begin
            if (!stat.pop) begin
               if (stat.full) begin
                  cmd.set_full = 1'b1;
                  state_in     = S_DONE;
               end else begin
                  cmd.push_init = 1'b1;
                  state_in      = S_UP_CHK;
               end
            end else begin
               if (stat.empty) begin
                  cmd.set_empty = 1'b1;
                  state_in      = S_DONE;
               end else begin
                  cmd.pop_init = 1'b1;
                  cmd.rd_en    = 1'b1;
                  cmd.rd_sel   = RD_LAST;
                  state_in     = S_POP_WAIT;
               end
            end
         end
         S_UP_CHK: begin
            if (stat.at_root) begin
               cmd.place = 1'b1;
               state_in  = S_DONE;
            end else begin
               cmd.rd_en  = 1'b1;
               cmd.rd_sel = RD_PARENT;
               state_in   = S_UP_CMP;
            end
         end
         S_UP_CMP: begin
            // parent moves down into the hole while the new item is smaller
            if (stat.up_smaller) begin
               cmd.move_up = 1'b1;
               state_in    = S_UP_CHK;
            end else begin
               cmd.place = 1'b1;
               state_in  = S_DONE;
            end
         end
         S_POP_WAIT: begin
            cmd.latch_val = 1'b1;
            state_in      = S_DN_CHK;
         end
         S_DN_CHK: begin
            if (!stat.has_left) begin
               cmd.place = 1'b1;
               state_in  = S_DONE;
            end else begin
               cmd.rd_en  = 1'b1;
               cmd.rd_sel = RD_LEFT;
               state_in   = S_DN_LEFT;
            end
         end
         S_DN_LEFT: begin
            // right child read is harmless when absent; datapath ignores it
            cmd.latch_left = 1'b1;
            cmd.rd_en      = 1'b1;
            cmd.rd_sel     = RD_RIGHT;
            state_in       = S_DN_CMP;
         end
         S_DN_CMP: begin
            if (stat.down_smaller) begin
               cmd.move_down = 1'b1;
               state_in      = S_DN_CHK;
            end else begin
               cmd.place = 1'b1;
               state_in  = S_DONE;
            end
         end
         S_DONE: begin
            state_in = S_IDLE;
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   assign busy      = (state_ff != S_IDLE);
   assign rsp_valid = (state_ff == S_DONE);

endmodule

/* design/bmhq_datapath.sv */
// Datapath of the binary min-heap queue: heap memory, count, hole position,
// sifting value and comparators. Depends on bmhq_pkg; driven by bmhq_ctrl.
module bmhq_datapath #(
   parameter int CAPACITY   = bmhq_pkg::DEF_CAPACITY,
   parameter int DATA_WIDTH = bmhq_pkg::DEF_DATA_WIDTH
) (
   input  logic                                 clock,
   input  logic                                 reset,
   input  bmhq_pkg::ctrl_cmd_type               cmd,
   output bmhq_pkg::dp_stat_type                stat,
   input  logic                                 req_type,
   input  logic signed [31:0]                   req_push_value,
   output logic signed [bmhq_pkg::TOP_WIDTH-1:0] top_value,
   output logic                                 top_valid,
   output logic [bmhq_pkg::COUNT_WIDTH-1:0]     entry_count,
   output logic [1:0]                           status
);
   import bmhq_pkg::*;

   localparam int AW = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
   localparam int CW = $clog2(CAPACITY + 1);
   localparam int KW = AW + 2;
   localparam int XW = (DATA_WIDTH > TOP_WIDTH) ? DATA_WIDTH : TOP_WIDTH;
   localparam int OW = (CW > COUNT_WIDTH) ? CW : COUNT_WIDTH;

   logic [DATA_WIDTH-1:0] heap_mem_ff [CAPACITY];
   logic [DATA_WIDTH-1:0] rd_data_ff;

   logic [AW-1:0]         pos_ff, pos_in;
   logic [AW-1:0]         child_pos_ff;
   logic [CW-1:0]         count_ff, count_in;
   logic [DATA_WIDTH-1:0] val_ff, child_ff, root_ff;
   logic                  pop_ff;
   status_code_type       status_ff;

   logic signed [XW-1:0]  push_ext, root_ext;
   logic [KW-1:0]         kid_left, kid_right, count_k;
   logic                  has_right, right_smaller;
   logic [AW-1:0]         parent_pos, best_pos, rd_addr;
   logic [CW-1:0]         count_m1;
   logic [DATA_WIDTH-1:0] best_val, wr_data;
   logic                  wr_en;
   logic [OW-1:0]         count_x;

   assign push_ext   = XW'(req_push_value);
   assign kid_left   = {1'b0, pos_ff, 1'b1};
   assign kid_right  = kid_left + KW'(1);
   assign count_k    = KW'(count_ff);
   assign has_right  = (kid_right < count_k);
   assign parent_pos = (pos_ff - AW'(1)) >> 1;
   assign count_m1   = count_ff - CW'(1);

   // left child wins a tie
   assign right_smaller = has_right && ($signed(rd_data_ff) < $signed(child_ff));
   assign best_val      = right_smaller ? rd_data_ff : child_ff;
   assign best_pos      = right_smaller ? (child_pos_ff + AW'(1)) : child_pos_ff;

   always_comb begin
      stat.pop          = pop_ff;
      stat.full         = (count_ff == CW'(CAPACITY));
      stat.empty        = (count_ff == '0);
      stat.at_root      = (pos_ff == '0);
      stat.has_left     = (kid_left < count_k);
      stat.up_smaller   = ($signed(val_ff) < $signed(rd_data_ff));
      stat.down_smaller = ($signed(best_val) < $signed(val_ff));
   end

   always_comb begin
      unique case (cmd.rd_sel)
         RD_PARENT: rd_addr = parent_pos;
         RD_LAST:   rd_addr = count_m1[AW-1:0];
         RD_LEFT:   rd_addr = kid_left[AW-1:0];
         RD_RIGHT:  rd_addr = kid_right[AW-1:0];
         default:   rd_addr = parent_pos;
      endcase
   end

   assign wr_en = cmd.place | cmd.move_up | cmd.move_down;

   always_comb begin
      priority if (cmd.place) begin
         wr_data = val_ff;
      end else if (cmd.move_up) begin
         wr_data = rd_data_ff;
      end else begin
         wr_data = best_val;
      end
   end

   always_ff @(posedge clock) begin
      if (wr_en) begin
         heap_mem_ff[pos_ff] <= wr_data;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.rd_en) begin
         rd_data_ff <= heap_mem_ff[rd_addr];
      end
   end

   always_comb begin
      pos_in   = pos_ff;
      count_in = count_ff;
      priority if (cmd.push_init) begin
         pos_in   = count_ff[AW-1:0];
         count_in = count_ff + CW'(1);
      end else if (cmd.pop_init) begin
         pos_in   = '0;
         count_in = count_m1;
      end else if (cmd.move_up) begin
         pos_in = parent_pos;
      end else if (cmd.move_down) begin
         pos_in = best_pos;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff <= '0;
      end else begin
         count_ff <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      pos_ff <= pos_in;
      if (cmd.latch_req) begin
         pop_ff    <= req_type;
         val_ff    <= push_ext[DATA_WIDTH-1:0];
         status_ff <= ST_DONE;
      end else if (cmd.latch_val) begin
         val_ff <= rd_data_ff;
      end
      if (cmd.set_empty) begin
         status_ff <= ST_POP_EMPTY;
      end else if (cmd.set_full) begin
         status_ff <= ST_PUSH_FULL;
      end
      if (cmd.latch_left) begin
         child_ff     <= rd_data_ff;
         child_pos_ff <= kid_left[AW-1:0];
      end
      // shadow the root so the minimum needs no extra read
      if (wr_en && (pos_ff == '0)) begin
         root_ff <= wr_data;
      end
   end

   assign root_ext    = XW'($signed(root_ff));
   assign top_valid   = (count_ff != '0);
   assign top_value   = top_valid ? root_ext[TOP_WIDTH-1:0] : '0;
   assign count_x     = OW'(count_ff);
   assign entry_count = count_x[COUNT_WIDTH-1:0];
   assign status      = status_ff;

endmodule
